// ----- rtl/core/rob_pkg.sv -----
// Reorder buffer package: request codes, field widths, payload structs.
// No dependencies; used by the interfaces, rob_ctrl and reorder_buffer_unit.
`timescale 1ns / 1ps
`default_nettype none

package rob_pkg;

  localparam int TAG_W  = 5;
  localparam int REG_W  = 6;
  localparam int WORD_W = 32;
  localparam int OCC_W  = 6;

  localparam logic [WORD_W-1:0] WORD_NONE = {WORD_W{1'b1}};

  typedef enum logic [1:0] {
    REQ_DISPATCH = 2'd0,
    REQ_COMMIT   = 2'd1,
    REQ_CAPTURE  = 2'd2
  } req_kind_t;

  typedef struct packed {
    logic [1:0]              req_type;
    logic signed [REG_W-1:0] dest_register;
    logic signed [WORD_W-1:0] instr_pc;
    logic [TAG_W-1:0]        result_tag;
    logic signed [WORD_W-1:0] result_value;
    logic signed [WORD_W-1:0] result_mem_addr;
    logic signed [WORD_W-1:0] result_mem_data;
    logic                    result_fault;
  } req_t;

  // decoded outcome of the request at the head of the pipe
  typedef struct packed {
    logic accepted;
    logic dispatch;
    logic commit;
    logic capture;
  } rob_op_t;

  // fields written by capture (and preset by dispatch)
  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic [WORD_W-1:0] maddr;
    logic [WORD_W-1:0] mem_data;
    logic              fault;
  } exec_t;

  // fields written only by dispatch
  typedef struct packed {
    logic [REG_W-1:0]  dest;
    logic [WORD_W-1:0] pc;
  } meta_t;

endpackage

`default_nettype wire

// ----- rtl/core/rob_if.sv -----
// Valid/ready channel interfaces for reorder buffer requests and responses.
// Depends on rob_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface rob_req_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        req_type;
  logic signed [rob_pkg::REG_W-1:0]  dest_register;
  logic signed [rob_pkg::WORD_W-1:0] instr_pc;
  logic [rob_pkg::TAG_W-1:0]         result_tag;
  logic signed [rob_pkg::WORD_W-1:0] result_value;
  logic signed [rob_pkg::WORD_W-1:0] result_mem_addr;
  logic signed [rob_pkg::WORD_W-1:0] result_mem_data;
  logic                              result_fault;

  modport source (
    output valid, req_type, dest_register, instr_pc, result_tag,
           result_value, result_mem_addr, result_mem_data, result_fault,
    input  ready
  );
  modport sink (
    input  valid, req_type, dest_register, instr_pc, result_tag,
           result_value, result_mem_addr, result_mem_data, result_fault,
    output ready
  );
endinterface

interface rob_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              accepted;
  logic [rob_pkg::TAG_W-1:0]         alloc_tag;
  logic signed [rob_pkg::REG_W-1:0]  commit_dest;
  logic signed [rob_pkg::WORD_W-1:0] commit_value;
  logic signed [rob_pkg::WORD_W-1:0] commit_mem_addr;
  logic signed [rob_pkg::WORD_W-1:0] commit_mem_data;
  logic signed [rob_pkg::WORD_W-1:0] commit_pc;
  logic                              commit_fault;
  logic [rob_pkg::OCC_W-1:0]         occupancy;

  modport source (
    output valid, accepted, alloc_tag, commit_dest, commit_value,
           commit_mem_addr, commit_mem_data, commit_pc, commit_fault, occupancy,
    input  ready
  );
  modport sink (
    input  valid, accepted, alloc_tag, commit_dest, commit_value,
           commit_mem_addr, commit_mem_data, commit_pc, commit_fault, occupancy,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/core/rob_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rob_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/rob_ctrl.sv -----
// Reorder buffer bookkeeping: head/tail pointers, entry count, ready marks.
// Decodes each request into a rob_pkg::rob_op_t and the slot addresses used.
`timescale 1ns / 1ps
`default_nettype none

module rob_ctrl #(
  parameter int ENTRIES = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             step,
  input  wire logic [1:0]                       req_type,
  input  wire logic [rob_pkg::TAG_W-1:0]        result_tag,
  output rob_pkg::rob_op_t                      op,
  output logic [$clog2(ENTRIES)-1:0]            alloc_idx,
  output logic [$clog2(ENTRIES)-1:0]            tag_idx,
  output logic [$clog2(ENTRIES)-1:0]            head_idx,
  output logic [rob_pkg::OCC_W-1:0]             occupancy
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);

  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [IDX_W-1:0]   tail_r, tail_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [ENTRIES-1:0] ready_r, ready_nxt;
  logic [IDX_W-1:0]   head_inc;
  logic               tag_ok;

  assign alloc_idx = (tail_r == IDX_W'(ENTRIES - 1)) ? '0 : tail_r + IDX_W'(1);
  assign head_inc  = (head_r == IDX_W'(ENTRIES - 1)) ? '0 : head_r + IDX_W'(1);
  assign tag_idx   = IDX_W'(result_tag);
  assign tag_ok    = 32'(result_tag) < 32'(ENTRIES);
  assign head_idx  = head_r;
  assign occupancy = rob_pkg::OCC_W'(count_nxt);

  always_comb begin
    op = '0;
    case (rob_pkg::req_kind_t'(req_type))
      rob_pkg::REQ_DISPATCH: begin
        op.dispatch = count_r != CNT_W'(ENTRIES);
        op.accepted = op.dispatch;
      end
      rob_pkg::REQ_COMMIT: begin
        op.commit   = (count_r != '0) && ready_r[head_r];
        op.accepted = op.commit;
      end
      rob_pkg::REQ_CAPTURE: begin
        op.capture  = tag_ok;
        op.accepted = 1'b1;
      end
      default: begin
        op = '0;
      end
    endcase
  end

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    ready_nxt = ready_r;
    if (op.dispatch) begin
      tail_nxt             = alloc_idx;
      count_nxt            = count_r + CNT_W'(1);
      ready_nxt[alloc_idx] = 1'b0;
    end
    if (op.commit) begin
      head_nxt  = head_inc;
      count_nxt = count_r - CNT_W'(1);
    end
    if (op.capture) begin
      ready_nxt[tag_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= IDX_W'(1);
      tail_r  <= '0;
      count_r <= '0;
      ready_r <= '0;
    end else if (step) begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      ready_r <= ready_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(ENTRIES))
    else $error("entry count above buffer depth");

  a_op_exclusive: assert property (@(posedge clk)
    $onehot0({op.dispatch, op.commit, op.capture}))
    else $error("more than one slot operation decoded");

  a_commit_moves_head: assert property (@(posedge clk) disable iff (!rst_n)
    step && op.commit |=> head_r != $past(head_r) && count_r == $past(count_r) - CNT_W'(1))
    else $error("commit did not retire the head entry");

  a_dispatch_clears_ready: assert property (@(posedge clk) disable iff (!rst_n)
    step && op.dispatch |=> !ready_r[$past(alloc_idx)] && tail_r == $past(alloc_idx))
    else $error("dispatched entry not allocated cleanly");

endmodule

`default_nettype wire

// ----- rtl/core/reorder_buffer_unit.sv -----
// Reorder buffer top level: request register, bookkeeping, entry RAMs, result register.
// Depends on rob_pkg, rob_if, rob_ram and rob_ctrl.
// An accepted request goes through the request register, then the result register.
// Throughput: one request per cycle while the output is not stalled by out_ch.ready.
// Reset: pointers, count, ready marks and valids reset synchronously; no clearing pass.
// Entry RAM contents are undefined after reset; commits read only dispatched slots.
`timescale 1ns / 1ps
`default_nettype none

module reorder_buffer_unit #(
  parameter int ENTRIES = 32
) (
  input wire logic  clk,
  input wire logic  rst_n,
  rob_req_if.sink   in_ch,
  rob_rsp_if.source out_ch
);

  localparam int IDX_W = $clog2(ENTRIES);

  rob_pkg::req_t            req_r;
  logic                     req_valid_r;
  logic                     out_valid_r;
  logic                     out_acc_r;
  logic                     out_commit_r;
  logic [rob_pkg::TAG_W-1:0] out_tag_r;
  logic [rob_pkg::OCC_W-1:0] out_occ_r;

  logic                     out_free;
  logic                     advance;
  rob_pkg::rob_op_t         op;
  logic [IDX_W-1:0]         alloc_idx;
  logic [IDX_W-1:0]         tag_idx;
  logic [IDX_W-1:0]         head_idx;
  logic [rob_pkg::OCC_W-1:0] occupancy;

  rob_pkg::exec_t           exec_wdata;
  rob_pkg::exec_t           exec_q;
  rob_pkg::meta_t           meta_wdata;
  rob_pkg::meta_t           meta_q;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign advance     = req_valid_r && out_free;
  assign in_ch.ready = !req_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      req_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      req_r.req_type        <= in_ch.req_type;
      req_r.dest_register   <= in_ch.dest_register;
      req_r.instr_pc        <= in_ch.instr_pc;
      req_r.result_tag      <= in_ch.result_tag;
      req_r.result_value    <= in_ch.result_value;
      req_r.result_mem_addr <= in_ch.result_mem_addr;
      req_r.result_mem_data <= in_ch.result_mem_data;
      req_r.result_fault    <= in_ch.result_fault;
    end
  end

  rob_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .req_type   (req_r.req_type),
    .result_tag (req_r.result_tag),
    .op         (op),
    .alloc_idx  (alloc_idx),
    .tag_idx    (tag_idx),
    .head_idx   (head_idx),
    .occupancy  (occupancy)
  );

  // dispatch presets the execution fields, capture overwrites them
  always_comb begin
    if (op.dispatch) begin
      exec_wdata.value    = rob_pkg::WORD_NONE;
      exec_wdata.maddr    = rob_pkg::WORD_NONE;
      exec_wdata.mem_data = '0;
      exec_wdata.fault    = 1'b0;
    end else begin
      exec_wdata.value    = req_r.result_value;
      exec_wdata.maddr    = req_r.result_mem_addr;
      exec_wdata.mem_data = req_r.result_mem_data;
      exec_wdata.fault    = req_r.result_fault;
    end
    meta_wdata.dest = req_r.dest_register;
    meta_wdata.pc   = req_r.instr_pc;
  end

  rob_ram #(.WIDTH($bits(rob_pkg::exec_t)), .DEPTH(ENTRIES)) u_exec_ram (
    .clk   (clk),
    .we    (advance && (op.dispatch || op.capture)),
    .waddr (op.dispatch ? alloc_idx : tag_idx),
    .wdata (exec_wdata),
    .re    (advance),
    .raddr (head_idx),
    .rdata (exec_q)
  );

  rob_ram #(.WIDTH($bits(rob_pkg::meta_t)), .DEPTH(ENTRIES)) u_meta_ram (
    .clk   (clk),
    .we    (advance && op.dispatch),
    .waddr (alloc_idx),
    .wdata (meta_wdata),
    .re    (advance),
    .raddr (head_idx),
    .rdata (meta_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= req_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_acc_r    <= op.accepted;
      out_commit_r <= op.commit;
      out_tag_r    <= op.dispatch ? rob_pkg::TAG_W'(alloc_idx) : '0;
      out_occ_r    <= occupancy;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.accepted        = out_acc_r;
  assign out_ch.alloc_tag       = out_tag_r;
  assign out_ch.occupancy       = out_occ_r;
  assign out_ch.commit_dest     = out_commit_r ? meta_q.dest : '0;
  assign out_ch.commit_pc       = out_commit_r ? meta_q.pc : '0;
  assign out_ch.commit_value    = out_commit_r ? exec_q.value : '0;
  assign out_ch.commit_mem_addr = out_commit_r ? exec_q.maddr : '0;
  assign out_ch.commit_mem_data = out_commit_r ? exec_q.mem_data : '0;
  assign out_ch.commit_fault    = out_commit_r ? exec_q.fault : 1'b0;

endmodule

`default_nettype wire
